@@ hw/rtl/spbu_pkg.sv @@
// ----------------------------------------------------------------------------
// spbu_pkg
// Shared types and constants for the stable pixel background update block.
// ----------------------------------------------------------------------------
`default_nettype none

package spbu_pkg;

   localparam int HISTORY_FRAMES = 12;
   localparam int FRAME_PIXELS   = 262144;   // power of two: index wraps by mask

   localparam int NUM_CH   = 3;
   localparam int CH_W     = 8;
   localparam int INDEX_W  = 18;
   localparam int PIX_AW   = $clog2(FRAME_PIXELS);
   localparam int SLOT_W   = $clog2(HISTORY_FRAMES);
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 8;

   localparam logic [CH_W-1:0] THRESHOLD_RESET = 8'd10;
   localparam logic [CH_W-1:0] BRIGHT_RESET    = 8'd245;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_CHANGE_THRESHOLD = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_BRIGHT_LEVEL     = 1'b1;

   // channel 0 red, 1 green, 2 blue
   typedef logic [NUM_CH-1:0][CH_W-1:0] pixel_type;
   typedef pixel_type [HISTORY_FRAMES-1:0] hist_type;

   typedef struct packed {
      logic [INDEX_W-1:0] pixel_index;
      pixel_type          rgb;
      logic               frame_end;
   } item_type;

   typedef enum logic {
      ST_IDLE,
      ST_CALC
   } state_type;

endpackage : spbu_pkg

`default_nettype wire

@@ hw/rtl/spbu_ifs.sv @@
// ----------------------------------------------------------------------------
// spbu_ifs
// Valid/ready channels for the pixel stream in and the updated pixels out.
// ----------------------------------------------------------------------------
`default_nettype none

interface spbu_req_if;
   logic       valid;
   logic       ready;
   logic [17:0] pixel_index;
   logic [7:0] red_in;
   logic [7:0] green_in;
   logic [7:0] blue_in;
   logic       frame_end;

   modport source (output valid, pixel_index, red_in, green_in, blue_in, frame_end,
                   input ready);
   modport sink   (input valid, pixel_index, red_in, green_in, blue_in, frame_end,
                   output ready);
endinterface : spbu_req_if

interface spbu_rsp_if;
   logic       valid;
   logic       ready;
   logic [17:0] pixel_out_index;
   logic [7:0] red_out;
   logic [7:0] green_out;
   logic [7:0] blue_out;
   logic       last_of_frame;

   modport source (output valid, pixel_out_index, red_out, green_out, blue_out,
                   last_of_frame, input ready);
   modport sink   (input valid, pixel_out_index, red_out, green_out, blue_out,
                   last_of_frame, output ready);
endinterface : spbu_rsp_if

`default_nettype wire

@@ hw/rtl/spbu_ram.sv @@
// ----------------------------------------------------------------------------
// spbu_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module spbu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule : spbu_ram

`default_nettype wire

@@ hw/rtl/spbu_merge.sv @@
// ----------------------------------------------------------------------------
// spbu_merge
// Per-channel update: insert the new pixel into its history slot and decide
// each output channel from the output image and the full history.
// ----------------------------------------------------------------------------
`default_nettype none

module spbu_merge (
   input  wire  spbu_pkg::pixel_type          new_pix,
   input  wire  spbu_pkg::pixel_type          old_out,
   input  wire  spbu_pkg::hist_type           hist_rd,
   input  wire  logic [spbu_pkg::SLOT_W-1:0]  slot,
   input  wire  logic                         primed,
   input  wire  logic [spbu_pkg::CH_W-1:0]    threshold,
   input  wire  logic [spbu_pkg::CH_W-1:0]    bright,
   output       spbu_pkg::hist_type           hist_wr,
   output       spbu_pkg::pixel_type          out_pix
);
   import spbu_pkg::*;

   function automatic logic [CH_W-1:0] absdiff(logic [CH_W-1:0] a, logic [CH_W-1:0] b);
      absdiff = (a > b) ? (a - b) : (b - a);
   endfunction

   logic [NUM_CH-1:0] hist_ok;

   // Write the new pixel into the current slot, or every slot while unprimed.
   always_comb begin
      for (int z = 0; z < HISTORY_FRAMES; z++) begin
         if (!primed || (SLOT_W'(z) == slot)) begin
            hist_wr[z] = new_pix;
         end else begin
            hist_wr[z] = hist_rd[z];
         end
      end
   end

   always_comb begin
      for (int c = 0; c < NUM_CH; c++) begin
         hist_ok[c] = 1'b1;
         for (int z = 0; z < HISTORY_FRAMES; z++) begin
            if (absdiff(new_pix[c], hist_wr[z][c]) > threshold) begin
               hist_ok[c] = 1'b0;
            end
         end
         if (!primed) begin
            out_pix[c] = new_pix[c];
         end else if (absdiff(old_out[c], new_pix[c]) <= threshold) begin
            out_pix[c] = old_out[c];
         end else if (new_pix[c] >= bright) begin
            out_pix[c] = new_pix[c];
         end else if (hist_ok[c]) begin
            out_pix[c] = new_pix[c];
         end else begin
            out_pix[c] = old_out[c];
         end
      end
   end

endmodule : spbu_merge

`default_nettype wire

@@ hw/rtl/stable_pixel_background_update_top.sv @@
// ----------------------------------------------------------------------------
// stable_pixel_background_update_top
// Stable pixel background accumulator: keeps a ring of past frames and an
// output image in two RAMs and updates one pixel per read-modify-write.
//
//  channel  | dir | handshake            | beat contents
//  ---------+-----+----------------------+-----------------------------------
//  req_bus  | in  | valid/ready          | pixel_index, red/green/blue_in,
//           |     |                      | frame_end
//  rsp_bus  | out | valid/ready          | pixel_out_index, red/green/blue_out,
//           |     |                      | last_of_frame
//  csr_*    | in  | csr_we, no wait      | csr_index, csr_wdata
//
// Each pixel issues the registered RAM read of its history word and output
// pixel on accept in the idle state, then merges and writes back in the merge
// state; one read-modify-write is in flight, so a new pixel waits for it.
// Reset restores write slot, primed flag, thresholds and handshake state; the
// RAM contents are undefined until the first frame has written them.
// A full output register that is not taken holds the pixel in the merge
// state; the RAM write-back waits with it, so no beat is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module stable_pixel_background_update_top (
   input  wire logic                              clock,
   input  wire logic                              reset,
   spbu_req_if.sink                               req_bus,
   spbu_rsp_if.source                             rsp_bus,
   input  wire logic                              csr_we,
   input  wire logic [spbu_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [spbu_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import spbu_pkg::*;

   state_type           state_ff, state_in;
   item_type            item_ff;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic                primed_ff, primed_in;
   logic [CH_W-1:0]     threshold_ff, bright_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   item_type            rsp_ff;

   logic                req_ready;
   logic                accept;
   logic                commit;

   hist_type            hist_rd, hist_wr;
   pixel_type           out_rd, out_new;

   // --- handshake -----------------------------------------------------------
   assign accept = req_bus.valid && req_ready;

   // --- state machine: next state --------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            if (commit) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // --- state machine: outputs ----------------------------------------------
   always_comb begin
      req_ready = 1'b0;
      commit    = 1'b0;
      case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         // merge only when the output register is free or being drained
         ST_CALC: commit = !rsp_valid_ff || rsp_bus.ready;
         default: begin
            req_ready = 1'b0;
            commit    = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // --- capture the accepted beat ---------------------------------------------
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.pixel_index <= req_bus.pixel_index;
         item_ff.rgb         <= {req_bus.blue_in, req_bus.green_in, req_bus.red_in};
         item_ff.frame_end   <= req_bus.frame_end;
      end
   end

   // --- configuration registers ------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
         bright_ff    <= BRIGHT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CHANGE_THRESHOLD: threshold_ff <= csr_wdata[CH_W-1:0];
            CSR_BRIGHT_LEVEL:     bright_ff    <= csr_wdata[CH_W-1:0];
            default: ;
         endcase
      end
   end

   // --- memories: history ring as one wide word per pixel, output image -----
   spbu_ram #(
      .WIDTH ($bits(hist_type)),
      .DEPTH (FRAME_PIXELS)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (commit),
      .wr_addr (item_ff.pixel_index[PIX_AW-1:0]),
      .wr_data (hist_wr),
      .rd_en   (accept),
      .rd_addr (req_bus.pixel_index[PIX_AW-1:0]),
      .rd_data (hist_rd)
   );

   spbu_ram #(
      .WIDTH ($bits(pixel_type)),
      .DEPTH (FRAME_PIXELS)
   ) u_out_ram (
      .clock   (clock),
      .wr_en   (commit),
      .wr_addr (item_ff.pixel_index[PIX_AW-1:0]),
      .wr_data (out_new),
      .rd_en   (accept),
      .rd_addr (req_bus.pixel_index[PIX_AW-1:0]),
      .rd_data (out_rd)
   );

   // --- merge the new pixel against history and output -------------------------
   spbu_merge u_merge (
      .new_pix   (item_ff.rgb),
      .old_out   (out_rd),
      .hist_rd   (hist_rd),
      .slot      (slot_ff),
      .primed    (primed_ff),
      .threshold (threshold_ff),
      .bright    (bright_ff),
      .hist_wr   (hist_wr),
      .out_pix   (out_new)
   );

   // --- frame bookkeeping: advance and wrap the write slot at frame end -------
   always_comb begin
      slot_in   = slot_ff;
      primed_in = primed_ff;
      if (commit && item_ff.frame_end) begin
         primed_in = 1'b1;
         if (slot_ff == SLOT_W'(HISTORY_FRAMES - 1)) begin
            slot_in = '0;
         end else begin
            slot_in = slot_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff   <= '0;
         primed_ff <= 1'b0;
      end else begin
         slot_ff   <= slot_in;
         primed_ff <= primed_in;
      end
   end

   // --- output register ------------------------------------------------------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_ff.pixel_index <= item_ff.pixel_index;
         rsp_ff.rgb         <= out_new;
         rsp_ff.frame_end   <= item_ff.frame_end;
      end
   end

   assign req_bus.ready           = req_ready;
   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.pixel_out_index = rsp_ff.pixel_index;
   assign rsp_bus.red_out         = rsp_ff.rgb[0];
   assign rsp_bus.green_out       = rsp_ff.rgb[1];
   assign rsp_bus.blue_out        = rsp_ff.rgb[2];
   assign rsp_bus.last_of_frame   = rsp_ff.frame_end;

   // --- assertions ---------------------------------------------------------------------
   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      slot_ff <= SLOT_W'(HISTORY_FRAMES - 1))
      else $error("write slot beyond history depth");

   a_slot_moves_on_frame_end: assert property (@(posedge clock) disable iff (reset)
      !$stable(slot_ff) |-> ($past(reset) || $past(commit && item_ff.frame_end)))
      else $error("write slot moved without a committed frame end");

   a_primed_on_frame_end: assert property (@(posedge clock) disable iff (reset)
      $rose(primed_ff) |-> $past(commit && item_ff.frame_end))
      else $error("primed set without a committed frame end");

   a_rsp_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_CALC))
      else $error("result raised outside the merge state");

   a_commit_returns_idle: assert property (@(posedge clock) disable iff (reset)
      commit |=> (state_ff == ST_IDLE))
      else $error("merge state held after write-back");

endmodule : stable_pixel_background_update_top

`default_nettype wire
